[hdl/dsss_pkg.sv]
// Shared constants and types for the delayed spike synapse step unit.
// Used by dsss_queue, dsss_mul and the top level; no dependencies.
package dsss_pkg;

	// delay line
	localparam int QUEUE_DEPTH = 64;
	localparam int QPOS_W      = $clog2(QUEUE_DEPTH);

	// conductance, unsigned Q8.16
	localparam int          G_W     = 24;
	localparam logic [23:0] G_MAX   = 24'hFFFFFF;
	localparam logic [23:0] G_ONE   = 24'h010000;
	localparam logic [23:0] G_FLOOR = 24'd65;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// configuration register indexes
	localparam int          CFG_IDX_W      = 3;
	localparam logic [2:0]  REG_MODE       = 3'd0;
	localparam logic [2:0]  REG_DELAY      = 3'd1;
	localparam logic [2:0]  REG_DECAY      = 3'd2;
	localparam logic [2:0]  REG_GAIN       = 3'd3;
	localparam logic [2:0]  REG_REVERSAL   = 3'd4;
	localparam logic [2:0]  REG_WEIGHT     = 3'd5;

	// configuration reset values
	localparam logic [5:0]  RST_DELAY      = 6'd1;
	localparam logic [15:0] RST_DECAY      = 16'd53656;
	localparam logic [15:0] RST_GAIN       = 16'd4096;
	localparam logic [15:0] RST_WEIGHT     = 16'd4096;

	// control from the sequencer to the delay line
	typedef struct packed {
		logic load;
		logic spike;
		logic clr;
	} q_ctrl_t;

endpackage

[hdl/delayed_spike_synapse_step_unit.sv]
// Delayed spike conductance synapse, one simulation tick per input transfer.
//
// Channels: an input channel (tick_time, presyn_spike, membrane_voltage,
// clear_all) and a result channel (spike_arrived, conductance_level,
// last_arrival_time, synaptic_current), both valid/ready. A separate write
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the six registers;
// cfg_ready is always high and writes belong between items.
// Timing: an item is taken when the unit is idle; its result is registered at
// the end of the DEC, GA, CUR and OUT steps. One item runs at a time: a
// single 33x25 multiplier is issued four times per item (gain*weight, decay,
// product with conductance, reversal term) under a small sequencer.
// The result sits in an output register; the unit takes the next item while
// that result waits. If the receiver stalls, the following item holds in the
// final step until the output register frees.
// Reset: conductance zero, delay line empty, last arrival all ones,
// registers at their defaults, no result pending.
// Depends on dsss_pkg, dsss_queue and dsss_mul.
module delayed_spike_synapse_step_unit (
	input  logic                clk,
	input  logic                arst_n,
	// input items
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         tick_time,
	input  logic                presyn_spike,
	input  logic signed [16:0]  membrane_voltage,
	input  logic                clear_all,
	// results
	output logic                out_valid,
	input  logic                out_ready,
	output logic                spike_arrived,
	output logic [23:0]         conductance_level,
	output logic [31:0]         last_arrival_time,
	output logic signed [47:0]  synaptic_current,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [dsss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [16:0]         cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_GA   = 3'd2;
	localparam logic [2:0] S_CUR  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]         state_q;

	// configuration registers
	logic               mode_q;
	logic [5:0]         delay_q;
	logic [15:0]        decay_q;
	logic [15:0]        gain_q;
	logic signed [16:0] rev_q;
	logic signed [15:0] weight_q;

	// synapse state and per-item data
	logic [23:0]        g_q;
	logic [31:0]        last_arrival_q;
	logic               dec_q;
	logic               arrived_q;
	logic signed [16:0] volt_q;
	logic signed [31:0] gw_q;
	logic signed [31:0] a_q;

	// output register
	logic               out_valid_q;
	logic               spike_arrived_q;
	logic [23:0]        conductance_q;
	logic [31:0]        last_arrival_out_q;
	logic signed [47:0] current_q;

	logic                               in_xfer;
	logic                               arrived;
	logic [24:0]                        g_sum;
	logic [23:0]                        g_new;
	logic signed [31:0]                 a_val;
	logic signed [17:0]                 diff;
	logic signed [47:0]                 current;
	logic                               out_load;
	logic                               mul_en;
	logic signed [dsss_pkg::MUL_A_W-1:0] mul_a;
	logic signed [dsss_pkg::MUL_B_W-1:0] mul_b;
	logic signed [dsss_pkg::MUL_P_W-1:0] prod_q;
	dsss_pkg::q_ctrl_t                  qctrl;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign qctrl.load  = in_xfer;
	assign qctrl.spike = presyn_spike;
	assign qctrl.clr   = clear_all;

	dsss_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (qctrl),
		.delay_ticks (delay_q),
		.arrived     (arrived)
	);

	// operand selection for the shared multiplier
	assign g_sum = {1'b0, g_q} + {1'b0, dsss_pkg::G_ONE};
	assign g_new = dec_q ? prod_q[39:16] : g_q;
	assign a_val = prod_q[55:24];
	assign diff  = {rev_q[16], rev_q} - {volt_q[16], volt_q};

	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_IDLE: begin
				mul_en = in_xfer;
				mul_a  = {{(dsss_pkg::MUL_A_W - 16){1'b0}}, gain_q};
				mul_b  = {{(dsss_pkg::MUL_B_W - 16){weight_q[15]}}, weight_q};
			end
			S_DEC: begin
				mul_en = 1'b1;
				mul_a  = {{(dsss_pkg::MUL_A_W - 24){1'b0}}, g_q};
				mul_b  = {{(dsss_pkg::MUL_B_W - 16){1'b0}}, decay_q};
			end
			S_GA: begin
				mul_en = 1'b1;
				mul_a  = {{(dsss_pkg::MUL_A_W - 32){gw_q[31]}}, gw_q};
				mul_b  = {{(dsss_pkg::MUL_B_W - 24){1'b0}}, g_new};
			end
			S_CUR: begin
				mul_en = 1'b1;
				mul_a  = {{(dsss_pkg::MUL_A_W - 32){a_val[31]}}, a_val};
				mul_b  = {{(dsss_pkg::MUL_B_W - 18){diff[17]}}, diff};
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	dsss_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	// mode 1 product already carries the negation through rev - v
	assign current = mode_q ? prod_q[55:8] : {{16{a_q[31]}}, a_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (in_xfer) state_q <= S_DEC;
				S_DEC:   state_q <= S_GA;
				S_GA:    state_q <= S_CUR;
				S_CUR:   state_q <= S_OUT;
				S_OUT:   if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			delay_q  <= dsss_pkg::RST_DELAY;
			decay_q  <= dsss_pkg::RST_DECAY;
			gain_q   <= dsss_pkg::RST_GAIN;
			rev_q    <= '0;
			weight_q <= dsss_pkg::RST_WEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dsss_pkg::REG_MODE:     mode_q   <= cfg_data[0];
				dsss_pkg::REG_DELAY:    delay_q  <= cfg_data[5:0];
				dsss_pkg::REG_DECAY:    decay_q  <= cfg_data[15:0];
				dsss_pkg::REG_GAIN:     gain_q   <= cfg_data[15:0];
				dsss_pkg::REG_REVERSAL: rev_q    <= cfg_data;
				dsss_pkg::REG_WEIGHT:   weight_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// conductance and arrival time: clear, arrival bump, zero at the floor, or mark for decay; S_GA stores the decay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q            <= '0;
			last_arrival_q <= '1;
			dec_q          <= 1'b0;
		end else if (in_xfer) begin
			dec_q <= 1'b0;
			if (clear_all) begin
				g_q            <= '0;
				last_arrival_q <= '1;
			end else if (arrived) begin
				g_q            <= g_sum[24] ? dsss_pkg::G_MAX : g_sum[23:0];
				last_arrival_q <= tick_time;
			end else if (g_q > dsss_pkg::G_FLOOR) begin
				dec_q <= 1'b1;
			end else begin
				g_q <= '0;
			end
		end else if (state_q == S_GA) begin
			g_q   <= g_new;
			dec_q <= 1'b0;
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			volt_q    <= membrane_voltage;
			arrived_q <= arrived && !clear_all;
		end
		if (state_q == S_DEC) begin
			gw_q <= prod_q[31:0];
		end
		if (state_q == S_CUR) begin
			a_q <= a_val;
		end
	end

	// output register: load on the final step, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			spike_arrived_q    <= arrived_q;
			conductance_q      <= g_q;
			last_arrival_out_q <= last_arrival_q;
			current_q          <= current;
		end
	end

	assign out_valid         = out_valid_q;
	assign spike_arrived     = spike_arrived_q;
	assign conductance_level = conductance_q;
	assign last_arrival_time = last_arrival_out_q;
	assign synaptic_current  = current_q;

	// an accepted item always starts the multiply sequence
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DEC)
		else $error("accepted item did not start the sequence");

	// a clear leaves the synapse state at its reset values
	a_clear_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && clear_all |=> g_q == '0 && last_arrival_q == '1 && !dec_q)
		else $error("clear did not reset synapse state");

	// a stalled result holds the next item in the final step
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_valid_q && !out_ready |=> state_q == S_OUT)
		else $error("result overwritten under stall");

	// finishing an item always presents a result
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("finished item produced no result");

endmodule

[hdl/dsss_queue.sv]
// Presynaptic spike delay line: one bit per pending tick, shifted once per item.
// Depends on dsss_pkg.
module dsss_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  dsss_pkg::q_ctrl_t ctrl,
	input  logic [5:0]        delay_ticks,
	output logic              arrived
);

	logic [dsss_pkg::QUEUE_DEPTH-1:0] queue_q;
	logic [dsss_pkg::QUEUE_DEPTH-1:0] queue_next;
	logic [dsss_pkg::QPOS_W-1:0]      pos;

	// clamp the insert position to the last slot
	always_comb begin
		if (7'(delay_ticks) > 7'(dsss_pkg::QUEUE_DEPTH - 1)) begin
			pos = dsss_pkg::QPOS_W'(dsss_pkg::QUEUE_DEPTH - 1);
		end else begin
			pos = dsss_pkg::QPOS_W'(delay_ticks);
		end
	end

	// clear or insert, then bit zero is this tick's arrival
	always_comb begin
		if (ctrl.clr) begin
			queue_next = '0;
		end else if (ctrl.spike) begin
			queue_next = queue_q | (dsss_pkg::QUEUE_DEPTH'(1) << pos);
		end else begin
			queue_next = queue_q;
		end
	end

	assign arrived = queue_next[0];

	// advance the line by one tick per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_q <= '0;
		end else if (ctrl.load) begin
			queue_q <= queue_next >> 1;
		end
	end

endmodule

[hdl/dsss_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on dsss_pkg for operand widths.
module dsss_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [dsss_pkg::MUL_A_W-1:0] op_a,
	input  logic signed [dsss_pkg::MUL_B_W-1:0] op_b,
	output logic signed [dsss_pkg::MUL_P_W-1:0] prod_q
);

	// hold the product until the next issue
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule
